// ===== design/emlk_pkg.sv =====
// emlk_pkg: shared types, widths and codes for the extent map lookup block.
// No dependencies; imported by emlk_cell and extent_map_lookup_top.
`default_nettype none
package emlk_pkg;

  localparam int EXTENT_SLOTS = 8;
  localparam int BLOCK_SHIFT  = 10;

  localparam int OFFSET_W = 48;
  localparam int BLOCK_W  = 40;
  localparam int LEN_W    = 24;
  localparam int BYTES_W  = LEN_W + BLOCK_SHIFT;  // 34
  localparam int LEFT_W   = BYTES_W + 1;          // 35
  localparam int STATUS_W = 2;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_ADD    = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  // Command beat as it walks down the row of cells.
  typedef struct packed {
    logic                valid;
    logic                cmd;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] offset;
    logic [BLOCK_W-1:0]  new_start;
    logic [LEN_W-1:0]    new_len;
    logic [OFFSET_W-1:0] total;      // bytes mapped by the cells passed so far
    logic [BLOCK_W-1:0]  found;
    logic [LEFT_W-1:0]   left;
    logic [BYTES_W-1:0]  off_in;
  } pkt_t;

endpackage
`default_nettype wire

// ===== design/extent_map_lookup_top.sv =====
// extent_map_lookup_top: extent table with add and byte-offset lookup.
// Depends on emlk_pkg and emlk_cell.
`default_nettype none
// Usage:
//   A command beat is taken on a rising edge where start is high and busy is
//   low. in_cmd selects lookup (map in_byte_offset) or add (store
//   in_start_block / in_extent_blocks in the first entry whose start is zero).
//   The command walks a row of EXTENT_SLOTS cells, one cell per cycle; each
//   cell holds one table entry and, on a lookup, adds its extent size to a
//   running total. Exactly one result beat per command shows on out_status,
//   out_found_block, out_bytes_left and out_offset_in_extent for one cycle
//   with out_valid high, registered as the walk leaves the last cell.
//   busy stays high from the accept edge until the walk leaves the last cell,
//   so a new command is not taken until the previous one has left the row.
//   The receiver cannot stall: each result beat lasts one cycle only.
//   Reset (rst_n low, synchronous) empties the table, drops any command in
//   flight and clears busy and out_valid.
module extent_map_lookup_top
  import emlk_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output      logic                busy,
  input  wire logic                in_cmd,
  input  wire logic [OFFSET_W-1:0] in_byte_offset,
  input  wire logic [BLOCK_W-1:0]  in_start_block,
  input  wire logic [LEN_W-1:0]    in_extent_blocks,
  output      logic                out_valid,
  output      logic [STATUS_W-1:0] out_status,
  output      logic [BLOCK_W-1:0]  out_found_block,
  output      logic [LEFT_W-1:0]   out_bytes_left,
  output      logic [BYTES_W-1:0]  out_offset_in_extent
);

  pkt_t chain [EXTENT_SLOTS+1];
  pkt_t last;

  logic busy_r, busy_nxt;
  logic out_valid_r;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [BLOCK_W-1:0]  found_r;
  logic [LEFT_W-1:0]   left_r;
  logic [BYTES_W-1:0]  off_r;

  always_comb begin
    chain[0].valid     = start && !busy_r;
    chain[0].cmd       = in_cmd;
    chain[0].done      = 1'b0;
    chain[0].status    = ST_OK;
    chain[0].offset    = in_byte_offset;
    chain[0].new_start = in_start_block;
    chain[0].new_len   = in_extent_blocks;
    chain[0].total     = '0;
    chain[0].found     = '0;
    chain[0].left      = '0;
    chain[0].off_in    = '0;
  end

  for (genvar i = 0; i < EXTENT_SLOTS; i++) begin : g_cell
    emlk_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .pkt_in  (chain[i]),
      .pkt_out (chain[i+1])
    );
  end

  assign last = chain[EXTENT_SLOTS];

  always_comb begin
    busy_nxt = busy_r;
    if (chain[0].valid) begin
      busy_nxt = 1'b1;
    end else if (last.valid) begin
      busy_nxt = 1'b0;
    end
  end

  // A walk that falls off the end: add found no vacant entry, lookup ran out.
  always_comb begin
    if (last.done) begin
      status_nxt = last.status;
    end else if (last.cmd == CMD_ADD) begin
      status_nxt = ST_FULL;
    end else begin
      status_nxt = ST_UNMAPPED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    found_r  <= last.found;
    left_r   <= last.left;
    off_r    <= last.off_in;
  end

  assign busy                 = busy_r;
  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_found_block      = found_r;
  assign out_bytes_left       = left_r;
  assign out_offset_in_extent = off_r;

endmodule
`default_nettype wire

// ===== design/emlk_cell.sv =====
// emlk_cell: one extent table entry plus one stage of the command walk.
// Depends on emlk_pkg.
`default_nettype none
module emlk_cell
  import emlk_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire pkt_t pkt_in,
  output pkt_t      pkt_out
);

  logic [BLOCK_W-1:0] start_r, start_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  pkt_t               pkt_r, pkt_nxt;

  logic [BYTES_W-1:0]  bytes;
  logic [OFFSET_W:0]   sum;
  logic                active;

  assign bytes  = {len_r, {BLOCK_SHIFT{1'b0}}};
  assign sum    = {1'b0, pkt_in.total} + {{(OFFSET_W+1-BYTES_W){1'b0}}, bytes};
  assign active = pkt_in.valid && !pkt_in.done;

  always_comb begin
    pkt_nxt   = pkt_in;
    start_nxt = start_r;
    len_nxt   = len_r;
    if (active) begin
      if (pkt_in.cmd == CMD_ADD) begin
        if (start_r == '0) begin
          start_nxt      = pkt_in.new_start;
          len_nxt        = pkt_in.new_len;
          pkt_nxt.done   = 1'b1;
          pkt_nxt.status = ST_OK;
        end
      end else begin
        if (len_r == '0) begin
          pkt_nxt.done   = 1'b1;
          pkt_nxt.status = ST_UNMAPPED;
        end else if (sum > {1'b0, pkt_in.offset}) begin
          // total <= offset holds here, so both differences fit their fields
          pkt_nxt.done   = 1'b1;
          pkt_nxt.status = ST_OK;
          pkt_nxt.found  = start_r;
          pkt_nxt.left   = LEFT_W'(sum - {1'b0, pkt_in.offset});
          pkt_nxt.off_in = BYTES_W'(pkt_in.offset - pkt_in.total);
        end else begin
          pkt_nxt.total = sum[OFFSET_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '0;
      len_r       <= '0;
      pkt_r.valid <= 1'b0;
    end else begin
      start_r     <= start_nxt;
      len_r       <= len_nxt;
      pkt_r.valid <= pkt_nxt.valid;
    end
    pkt_r.cmd       <= pkt_nxt.cmd;
    pkt_r.done      <= pkt_nxt.done;
    pkt_r.status    <= pkt_nxt.status;
    pkt_r.offset    <= pkt_nxt.offset;
    pkt_r.new_start <= pkt_nxt.new_start;
    pkt_r.new_len   <= pkt_nxt.new_len;
    pkt_r.total     <= pkt_nxt.total;
    pkt_r.found     <= pkt_nxt.found;
    pkt_r.left      <= pkt_nxt.left;
    pkt_r.off_in    <= pkt_nxt.off_in;
  end

  assign pkt_out = pkt_r;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for extent_map_lookup_top (add / byte-offset lookup).
// Depends on emlk_pkg and the design files; keeps its own extent table to predict
// each result beat and compares every beat field by field.
module tb_top;
  import emlk_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 2 * (EXTENT_SLOTS + 1) + 4;

  typedef struct packed {
    logic                cmd;
    logic [OFFSET_W-1:0] offset;
    logic [BLOCK_W-1:0]  blk;
    logic [LEN_W-1:0]    len;
    logic                hold;   // present only once every result is back
    logic [3:0]          gap;    // idle cycles before the beat
  } ext_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLOCK_W-1:0]  found;
    logic [LEFT_W-1:0]   left;
    logic [BYTES_W-1:0]  off_in;
  } map_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_cmd = CMD_LOOKUP;
  logic [OFFSET_W-1:0] in_byte_offset = '0;
  logic [BLOCK_W-1:0]  in_start_block = '0;
  logic [LEN_W-1:0]    in_extent_blocks = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [BLOCK_W-1:0]  out_found_block;
  logic [LEFT_W-1:0]   out_bytes_left;
  logic [BYTES_W-1:0]  out_offset_in_extent;

  extent_map_lookup_top dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_cmd               (in_cmd),
    .in_byte_offset       (in_byte_offset),
    .in_start_block       (in_start_block),
    .in_extent_blocks     (in_extent_blocks),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_found_block      (out_found_block),
    .out_bytes_left       (out_bytes_left),
    .out_offset_in_extent (out_offset_in_extent)
  );

  // Shadow extent table
  logic [BLOCK_W-1:0] ext_start [EXTENT_SLOTS];
  logic [LEN_W-1:0]   ext_len   [EXTENT_SLOTS];

  ext_cmd_t    pend_q[$];
  map_result_t exp_q[$];
  ext_cmd_t    cur;
  int          gap_cnt = 0;
  int          n_taken = 0;
  int          n_results = 0;
  int          n_err = 0;
  int          idle_cycles = 0;
  bit          burst = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic map_result_t predict_map(ext_cmd_t it);
    map_result_t r;
    logic [63:0] run_total;
    logic [63:0] ext_bytes;
    bit          done;
    r = '0;
    done = 1'b0;
    if (it.cmd == CMD_ADD) begin
      r.status = ST_FULL;
      for (int i = 0; i < EXTENT_SLOTS; i++) begin
        if (!done && ext_start[i] == '0) begin
          ext_start[i] = it.blk;
          ext_len[i]   = it.len;
          r.status     = ST_OK;
          done         = 1'b1;
        end
      end
    end else begin
      r.status  = ST_UNMAPPED;
      run_total = '0;
      for (int i = 0; i < EXTENT_SLOTS; i++) begin
        ext_bytes = 64'(ext_len[i]) << BLOCK_SHIFT;
        if (!done) begin
          if (ext_len[i] == '0) begin
            done = 1'b1;
          end else if (run_total + ext_bytes > 64'(it.offset)) begin
            r.status = ST_OK;
            r.found  = ext_start[i];
            r.left   = LEFT_W'(run_total + ext_bytes - 64'(it.offset));
            r.off_in = BYTES_W'(64'(it.offset) - run_total);
            done     = 1'b1;
          end else begin
            run_total = run_total + ext_bytes;
          end
        end
      end
    end
    return r;
  endfunction

  // Bytes mapped ahead of entry k along the lookup walk
  function automatic logic [63:0] walk_edge(int k);
    logic [63:0] acc;
    bit          stop;
    acc  = '0;
    stop = 1'b0;
    for (int i = 0; i < k; i++) begin
      if (ext_len[i] == '0) stop = 1'b1;
      if (!stop) acc = acc + (64'(ext_len[i]) << BLOCK_SHIFT);
    end
    return acc;
  endfunction

  task automatic push_item(input logic cmd, input logic [OFFSET_W-1:0] off,
                           input logic [BLOCK_W-1:0] blk, input logic [LEN_W-1:0] len,
                           input bit hold);
    ext_cmd_t it;
    it.cmd    = cmd;
    it.offset = off;
    it.blk    = blk;
    it.len    = len;
    it.hold   = hold;
    it.gap    = burst ? 4'd0 : 4'($urandom_range(0, 10));
    pend_q.push_back(it);
  endtask

  task automatic gen_lookup();
    logic [63:0] span;
    logic [63:0] o;
    span = walk_edge(EXTENT_SLOTS);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: o = {$urandom, $urandom} % (span + 64'd2048);
      4, 5:       o = walk_edge($urandom_range(0, EXTENT_SLOTS)) + $urandom_range(0, 2) - 1;
      6:          o = span;
      7, 8:       o = {$urandom, $urandom};
      default:    o = span - 1;
    endcase
    push_item(CMD_LOOKUP, o[OFFSET_W-1:0], BLOCK_W'({$urandom, $urandom}),
              LEN_W'($urandom), $urandom_range(0, 39) == 0);
  endtask

  // keep=1 writes a nonzero start so the entry stays taken; otherwise start 0
  // leaves the entry open for the next add.
  task automatic gen_add(input bit keep);
    logic [BLOCK_W-1:0] blk;
    logic [LEN_W-1:0]   len;
    if (keep) begin
      blk = BLOCK_W'({$urandom, $urandom});
      if (blk == '0) blk = BLOCK_W'(1);
      len = ($urandom_range(0, 9) == 0) ? {LEN_W{1'b1}} : LEN_W'($urandom_range(1, 1023));
    end else begin
      blk = '0;
      case ($urandom_range(0, 7))
        0:       len = '0;
        1:       len = {LEN_W{1'b1}};
        2:       len = LEN_W'($urandom);
        default: len = LEN_W'($urandom_range(1, 255));
      endcase
    end
    push_item(CMD_ADD, OFFSET_W'({$urandom, $urandom}), blk, len,
              $urandom_range(0, 39) == 0);
  endtask

  // Driver
  always @(posedge clk) begin
    logic took;
    logic drained;
    logic next_start;
    took       = start && !busy;
    next_start = start && !took;
    if (rst_n) begin
      if (took) begin
        exp_q.push_back(predict_map(cur));
        n_taken <= n_taken + 1;
      end
      drained = !took && (n_taken == n_results + int'(out_valid));
      if (!next_start && pend_q.size() != 0) begin
        if (gap_cnt < int'(pend_q[0].gap) || (pend_q[0].hold && !drained)) begin
          gap_cnt <= gap_cnt + 1;
        end else begin
          cur = pend_q.pop_front();
          in_cmd           <= cur.cmd;
          in_byte_offset   <= cur.offset;
          in_start_block   <= cur.blk;
          in_extent_blocks <= cur.len;
          next_start = 1'b1;
          gap_cnt <= 0;
        end
      end
      start <= next_start;
    end
  end

  // Monitor
  always @(posedge clk) begin
    map_result_t want;
    if (rst_n && out_valid) begin
      if (n_results >= n_taken) begin
        $error("result beat with no command outstanding");
        n_err++;
      end else begin
        want = exp_q.pop_front();
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, got %0d", want.status, out_status);
          n_err++;
        end
        if (out_found_block !== want.found) begin
          $error("out_found_block: expected %h, got %h", want.found, out_found_block);
          n_err++;
        end
        if (out_bytes_left !== want.left) begin
          $error("out_bytes_left: expected %h, got %h", want.left, out_bytes_left);
          n_err++;
        end
        if (out_offset_in_extent !== want.off_in) begin
          $error("out_offset_in_extent: expected %h, got %h", want.off_in,
                 out_offset_in_extent);
          n_err++;
        end
        n_results <= n_results + 1;
      end
    end
  end

  // Watchdog: cycles with neither a command nor a result beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < EXTENT_SLOTS; i++) begin
      ext_start[i] = '0;
      ext_len[i]   = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, vacant-but-written entries, zero length, boundaries
    push_item(CMD_LOOKUP, '0, '0, '0, 1'b0);
    push_item(CMD_LOOKUP, {OFFSET_W{1'b1}}, {BLOCK_W{1'b1}}, {LEN_W{1'b1}}, 1'b0);
    push_item(CMD_ADD, '0, '0, {LEN_W{1'b1}}, 1'b0);                 // start 0 stays open
    push_item(CMD_LOOKUP, '0, '0, '0, 1'b0);                          // walk takes start-0 entry
    push_item(CMD_LOOKUP, 48'h3_FFFF_FBFF, '0, '0, 1'b0);             // last byte of max extent
    push_item(CMD_LOOKUP, 48'h3_FFFF_FC00, '0, '0, 1'b0);             // just past it
    push_item(CMD_ADD, '0, '0, '0, 1'b0);                             // overwrites entry 0
    push_item(CMD_LOOKUP, '0, '0, '0, 1'b0);                          // zero length stops walk
    push_item(CMD_ADD, '0, {BLOCK_W{1'b1}}, 24'd2, 1'b0);
    push_item(CMD_ADD, '0, '0, '0, 1'b0);
    push_item(CMD_LOOKUP, 48'd2047, '0, '0, 1'b0);
    push_item(CMD_LOOKUP, 48'd2048, '0, '0, 1'b0);
    push_item(CMD_ADD, '0, 40'd1, 24'd1, 1'b0);
    push_item(CMD_LOOKUP, 48'd2048, '0, '0, 1'b0);
    push_item(CMD_ADD, '0, 40'h123, 24'd5, 1'b0);
    push_item(CMD_LOOKUP, 48'd3072, '0, '0, 1'b1);
    push_item(CMD_ADD, 48'hA5A5_5A5A_F00F, 40'h55, 24'h10, 1'b0);
    push_item(CMD_LOOKUP, 48'd3072 + 48'd5120 + 48'h4000 - 48'd1, 40'hFF_FFFF_FFFF,
              24'hFF_FFFF, 1'b0);

    // Random: mostly reusable entries, a few permanent ones
    for (int n = 0; n < 300; n++) begin
      while (pend_q.size() != 0) @(negedge clk);
      burst = (n >= 120 && n < 180);
      if ($urandom_range(0, 9) < 6) gen_lookup();
      else gen_add($urandom_range(0, 7) == 0);
    end

    // Random: fill the table and run into the full case
    for (int n = 0; n < 130; n++) begin
      while (pend_q.size() != 0) @(negedge clk);
      burst = (n < 40);
      if ($urandom_range(0, 2) == 0) gen_add(1'b1);
      else gen_lookup();
    end
    burst = 1'b0;

    // Past every mapped extent, with the whole table walked
    while (pend_q.size() != 0) @(negedge clk);
    push_item(CMD_LOOKUP, {OFFSET_W{1'b1}}, '0, '0, 1'b1);
    push_item(CMD_LOOKUP, OFFSET_W'(walk_edge(EXTENT_SLOTS)), '0, '0, 1'b0);
    push_item(CMD_LOOKUP, OFFSET_W'(walk_edge(EXTENT_SLOTS) - 1), '0, '0, 1'b0);

    while (pend_q.size() != 0 || start || n_results != n_taken) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (n_err == 0 && exp_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
